@@ hw/rtl/ocs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocs_pkg
// Shared types, constants and tables of the oRGB chroma shift pipeline.
// ----------------------------------------------------------------------------
package ocs_pkg;

   // cordic stage count, never more than the arc table holds
   localparam int CORDIC_STAGES = 16;
   localparam int ARC_COUNT     = 24;
   localparam int RUN_STAGES    = (CORDIC_STAGES < ARC_COUNT) ? CORDIC_STAGES : ARC_COUNT;

   // widths
   localparam int VALUE_W  = 20;   // q16 values with headroom
   localparam int CORDIC_W = 30;   // q24 cordic vectors with gain growth
   localparam int ANGLE_W  = 20;   // q16 radians
   localparam int EXT_W    = 24;   // scaled angles
   localparam int PROD_W   = 36;   // matrix products
   localparam int GAIN_W   = 48;   // cordic gain products
   localparam int SHIFT_W  = 18;   // offset register width

   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic signed [CORDIC_W-1:0] cordic_type;
   typedef logic signed [ANGLE_W-1:0]  angle_type;
   typedef logic signed [EXT_W-1:0]    ext_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [GAIN_W-1:0]   gain_type;
   typedef logic signed [SHIFT_W-1:0]  shift_type;

   // luma and chroma that travel beside the cordic units
   typedef struct packed {
      value_type luma;
      value_type c1;
      value_type c2;
      logic      skip;
   } side_type;

   // register indexes
   localparam logic [1:0] REG_YELLOW_BLUE = 2'd0;
   localparam logic [1:0] REG_RED_GREEN   = 2'd1;

   // q16 constants
   localparam value_type ONE_Q16  = value_type'(65536);
   localparam angle_type PI2_Q16  = angle_type'(102944);
   localparam angle_type PI3_Q16  = angle_type'(68629);
   localparam angle_type PI4_Q16  = angle_type'(51472);
   localparam gain_type  GAIN_Q16 = gain_type'(39797);
   localparam gain_type  GAIN_RND = gain_type'(64'sd1 <<< 23);

   // matrix coefficients
   localparam prod_type K_LR   = prod_type'(19595);
   localparam prod_type K_LG   = prod_type'(38470);
   localparam prod_type K_LB   = prod_type'(7471);
   localparam prod_type K_C2   = prod_type'(56754);
   localparam prod_type K_RC1  = prod_type'(7471);
   localparam prod_type K_RC2  = prod_type'(48733);
   localparam prod_type K_GC2  = prod_type'(26942);
   localparam prod_type K_BC1  = prod_type'(58065);
   localparam prod_type K_BC2  = prod_type'(10899);
   localparam prod_type HALF_Q16 = prod_type'(32768);

   // floor division by three through a reciprocal, operand kept positive
   localparam int         DIV_BIAS_LOG = 20;
   localparam ext_type    DIV_BIAS     = ext_type'(3 * (1 << DIV_BIAS_LOG));
   localparam int         RECIP_SHIFT  = 25;
   localparam logic [47:0] RECIP_THREE = 48'd11184811;

   // arc table atan(2^-i), q16
   function automatic angle_type arc_of(input int idx);
      angle_type a;
      case (idx)
         0:  a = angle_type'(51472);
         1:  a = angle_type'(30386);
         2:  a = angle_type'(16055);
         3:  a = angle_type'(8150);
         4:  a = angle_type'(4091);
         5:  a = angle_type'(2047);
         6:  a = angle_type'(1024);
         7:  a = angle_type'(512);
         8:  a = angle_type'(256);
         9:  a = angle_type'(128);
         10: a = angle_type'(64);
         11: a = angle_type'(32);
         12: a = angle_type'(16);
         13: a = angle_type'(8);
         14: a = angle_type'(4);
         15: a = angle_type'(2);
         16: a = angle_type'(1);
         default: a = angle_type'(0);
      endcase
      return a;
   endfunction

   function automatic value_type clamp_val(input value_type v, input value_type lo,
                                           input value_type hi);
      value_type r;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

endpackage

@@ hw/rtl/orgb_color_shift.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orgb_color_shift
// Chroma shift of 8-bit RGB pixels in the oRGB color space, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel transfer happens on a clock edge with start high and busy low.
//   busy stays low: the pipeline takes a new pixel every cycle.
//   The shifted pixel appears on rsp_red_out/green/blue for one cycle with
//   rsp_valid high. Each pixel passes through the four cordic pipelines
//   (vectoring and rotation, forward and inverse), S + 1 and S + 3 stages
//   each (S = cordic stage count), plus matrix, angle map and clamp stages.
//   The receiver cannot stall; results leave in transfer order.
//   Offsets are written through the csr_ port (index 0 yellow-blue,
//   index 1 red-green, signed q16, 18 bits); other indexes are ignored.
//   csr_ready is always high. Write them only while no pixel is in flight.
//   Synchronous reset clears all valid bits and both offsets to zero.
// ----------------------------------------------------------------------------
module orgb_color_shift (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic signed [17:0] csr_data
);

   // offset registers
   ocs_pkg::shift_type yb_ff;
   ocs_pkg::shift_type rg_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         yb_ff <= '0;
         rg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ocs_pkg::REG_YELLOW_BLUE: yb_ff <= csr_data;
            ocs_pkg::REG_RED_GREEN:   rg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // front: scale to q16, then matrix to luma and chroma
   // ------------------------------------------------------------------
   logic               s1_v_ff, s2_v_ff, s3_v_ff;
   ocs_pkg::value_type s1_r_ff, s1_g_ff, s1_b_ff;
   ocs_pkg::prod_type  s2_lr_ff, s2_lg_ff, s2_lb_ff, s2_c2_ff;
   ocs_pkg::value_type s2_c1_ff;
   ocs_pkg::side_type  s3_side_ff;
   ocs_pkg::side_type  s3_side_in;

   // round(v * 65536 / 255) = 257 v + msb
   function automatic ocs_pkg::value_type scale_byte(input logic [7:0] v);
      return ocs_pkg::value_type'({1'b0, v, v}) + ocs_pkg::value_type'(v[7]);
   endfunction

   always_comb begin
      s3_side_in.luma = ocs_pkg::value_type'((s2_lr_ff + s2_lg_ff + s2_lb_ff
                                              + ocs_pkg::HALF_Q16) >>> 16);
      s3_side_in.c1   = s2_c1_ff;
      s3_side_in.c2   = ocs_pkg::value_type'((s2_c2_ff + ocs_pkg::HALF_Q16) >>> 16);
      s3_side_in.skip = (s3_side_in.c1 == 0) && (s3_side_in.c2 == 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start && !busy;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_r_ff    <= scale_byte(req_red_in);
      s1_g_ff    <= scale_byte(req_green_in);
      s1_b_ff    <= scale_byte(req_blue_in);
      s2_lr_ff   <= ocs_pkg::prod_type'(s1_r_ff) * ocs_pkg::K_LR;
      s2_lg_ff   <= ocs_pkg::prod_type'(s1_g_ff) * ocs_pkg::K_LG;
      s2_lb_ff   <= ocs_pkg::prod_type'(s1_b_ff) * ocs_pkg::K_LB;
      s2_c2_ff   <= ocs_pkg::prod_type'(s1_r_ff - s1_g_ff) * ocs_pkg::K_C2;
      s2_c1_ff   <= ((s1_r_ff + s1_g_ff + ocs_pkg::value_type'(1)) >>> 1) - s1_b_ff;
      s3_side_ff <= s3_side_in;
   end

   // ------------------------------------------------------------------
   // forward angle and remap
   // ------------------------------------------------------------------
   logic               v1_v;
   ocs_pkg::angle_type v1_z;
   ocs_pkg::side_type  v1_side;

   ocs_vec u_vec_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_c1     (s3_side_ff.c1),
      .in_c2     (s3_side_ff.c2),
      .in_side   (s3_side_ff),
      .out_valid (v1_v),
      .out_z     (v1_z),
      .out_side  (v1_side)
   );

   logic               d1_v_ff;
   ocs_pkg::angle_type d1_z_ff;
   ocs_pkg::angle_type d1_z_in;
   ocs_pkg::side_type  d1_side_ff;

   // piecewise forward map, delta = t0 - t
   always_comb begin
      ocs_pkg::ext_type t;
      ocs_pkg::ext_type t6;
      ocs_pkg::ext_type t0;
      t  = ocs_pkg::ext_type'(v1_z);
      t6 = (t <<< 2) + (t <<< 1);
      if (v1_z >= ocs_pkg::PI3_Q16) begin
         t0 = ((t6 + ocs_pkg::ext_type'(4)) >>> 3) + ocs_pkg::ext_type'(ocs_pkg::PI4_Q16);
      end else if (v1_z <= -ocs_pkg::PI3_Q16) begin
         t0 = ((t6 + ocs_pkg::ext_type'(4)) >>> 3) - ocs_pkg::ext_type'(ocs_pkg::PI4_Q16);
      end else begin
         t0 = (t6 + ocs_pkg::ext_type'(2)) >>> 2;
      end
      d1_z_in = ocs_pkg::angle_type'(t0 - t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff <= 1'b0;
      end else begin
         d1_v_ff <= v1_v;
      end
   end

   always_ff @(posedge clock) begin
      d1_z_ff    <= d1_z_in;
      d1_side_ff <= v1_side;
   end

   logic               r1_v;
   ocs_pkg::value_type r1_x, r1_y;
   ocs_pkg::side_type  r1_side;

   ocs_rot u_rot_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_v_ff),
      .in_x      (d1_side_ff.c1),
      .in_y      (d1_side_ff.c2),
      .in_z      (d1_z_ff),
      .in_side   (d1_side_ff),
      .out_valid (r1_v),
      .out_x     (r1_x),
      .out_y     (r1_y),
      .out_side  (r1_side)
   );

   // ------------------------------------------------------------------
   // offsets and clamp
   // ------------------------------------------------------------------
   logic               o_v_ff;
   ocs_pkg::side_type  o_side_ff;
   ocs_pkg::side_type  o_side_in;

   always_comb begin
      ocs_pkg::value_type c1;
      ocs_pkg::value_type c2;
      c1 = r1_side.skip ? r1_side.c1 : r1_x;
      c2 = r1_side.skip ? r1_side.c2 : r1_y;
      o_side_in.c1   = ocs_pkg::clamp_val(c1 + ocs_pkg::value_type'(yb_ff),
                                          -ocs_pkg::ONE_Q16, ocs_pkg::ONE_Q16);
      o_side_in.c2   = ocs_pkg::clamp_val(c2 + ocs_pkg::value_type'(rg_ff),
                                          -ocs_pkg::ONE_Q16, ocs_pkg::ONE_Q16);
      o_side_in.luma = ocs_pkg::clamp_val(r1_side.luma, '0, ocs_pkg::ONE_Q16);
      o_side_in.skip = (o_side_in.c1 == 0) && (o_side_in.c2 == 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else begin
         o_v_ff <= r1_v;
      end
   end

   always_ff @(posedge clock) begin
      o_side_ff <= o_side_in;
   end

   // ------------------------------------------------------------------
   // inverse angle and remap
   // ------------------------------------------------------------------
   logic               v2_v;
   ocs_pkg::angle_type v2_z;
   ocs_pkg::side_type  v2_side;

   ocs_vec u_vec_inv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (o_v_ff),
      .in_c1     (o_side_ff.c1),
      .in_c2     (o_side_ff.c2),
      .in_side   (o_side_ff),
      .out_valid (v2_v),
      .out_z     (v2_z),
      .out_side  (v2_side)
   );

   // divide by six as halving then reciprocal of three on a biased operand
   logic               i1_v_ff, i2_v_ff, i3_v_ff;
   logic [22:0]        i1_m_ff;
   ocs_pkg::angle_type i1_t_ff, i2_t_ff;
   ocs_pkg::angle_type i1_off_ff, i2_off_ff;
   ocs_pkg::side_type  i1_side_ff, i2_side_ff, i3_side_ff;
   logic [47:0]        i2_q_ff;
   ocs_pkg::angle_type i3_z_ff;
   logic [22:0]        i1_m_in;
   ocs_pkg::angle_type i1_off_in;
   ocs_pkg::angle_type i3_z_in;

   always_comb begin
      ocs_pkg::ext_type t;
      ocs_pkg::ext_type n;
      t = ocs_pkg::ext_type'(v2_z);
      if (v2_z >= ocs_pkg::PI2_Q16) begin
         n         = (t <<< 3) + ocs_pkg::ext_type'(3);
         i1_off_in = -ocs_pkg::PI3_Q16;
      end else if (v2_z <= -ocs_pkg::PI2_Q16) begin
         n         = (t <<< 3) + ocs_pkg::ext_type'(3);
         i1_off_in = ocs_pkg::PI3_Q16;
      end else begin
         n         = (t <<< 2) + ocs_pkg::ext_type'(3);
         i1_off_in = '0;
      end
      i1_m_in = 23'((n >>> 1) + ocs_pkg::DIV_BIAS);
   end

   always_comb begin
      ocs_pkg::ext_type quot;
      quot    = ocs_pkg::ext_type'(i2_q_ff >> ocs_pkg::RECIP_SHIFT)
              - ocs_pkg::ext_type'(1 << ocs_pkg::DIV_BIAS_LOG);
      i3_z_in = ocs_pkg::angle_type'(quot + ocs_pkg::ext_type'(i2_off_ff)
                                     - ocs_pkg::ext_type'(i2_t_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i1_v_ff <= 1'b0;
         i2_v_ff <= 1'b0;
         i3_v_ff <= 1'b0;
      end else begin
         i1_v_ff <= v2_v;
         i2_v_ff <= i1_v_ff;
         i3_v_ff <= i2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      i1_m_ff    <= i1_m_in;
      i1_t_ff    <= v2_z;
      i1_off_ff  <= i1_off_in;
      i1_side_ff <= v2_side;
      i2_q_ff    <= 48'(i1_m_ff) * ocs_pkg::RECIP_THREE;
      i2_t_ff    <= i1_t_ff;
      i2_off_ff  <= i1_off_ff;
      i2_side_ff <= i1_side_ff;
      i3_z_ff    <= i3_z_in;
      i3_side_ff <= i2_side_ff;
   end

   logic               r2_v;
   ocs_pkg::value_type r2_x, r2_y;
   ocs_pkg::side_type  r2_side;

   ocs_rot u_rot_inv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (i3_v_ff),
      .in_x      (i3_side_ff.c1),
      .in_y      (i3_side_ff.c2),
      .in_z      (i3_z_ff),
      .in_side   (i3_side_ff),
      .out_valid (r2_v),
      .out_x     (r2_x),
      .out_y     (r2_y),
      .out_side  (r2_side)
   );

   // ------------------------------------------------------------------
   // clamp, inverse matrix, byte conversion
   // ------------------------------------------------------------------
   logic               c_v_ff, b1_v_ff, b2_v_ff, b3_v_ff;
   ocs_pkg::value_type c_l_ff, c_c1_ff, c_c2_ff;
   ocs_pkg::value_type b1_l_ff;
   ocs_pkg::prod_type  b1_rc1_ff, b1_rc2_ff, b1_gc2_ff, b1_bc1_ff, b1_bc2_ff;
   ocs_pkg::value_type b2_r_ff, b2_g_ff, b2_b_ff;
   logic [7:0]         b3_r_ff, b3_g_ff, b3_b_ff;

   function automatic logic [7:0] to_byte(input ocs_pkg::value_type v);
      logic [16:0] c;
      logic [25:0] p;
      c = 17'(ocs_pkg::clamp_val(v, '0, ocs_pkg::ONE_Q16));
      p = (26'(c) << 8) - 26'(c) + 26'd32768;
      return p[23:16];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff  <= 1'b0;
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
      end else begin
         c_v_ff  <= r2_v;
         b1_v_ff <= c_v_ff;
         b2_v_ff <= b1_v_ff;
         b3_v_ff <= b2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_l_ff    <= r2_side.luma;
      c_c1_ff   <= r2_side.skip ? r2_side.c1
                 : ocs_pkg::clamp_val(r2_x, -ocs_pkg::ONE_Q16, ocs_pkg::ONE_Q16);
      c_c2_ff   <= r2_side.skip ? r2_side.c2
                 : ocs_pkg::clamp_val(r2_y, -ocs_pkg::ONE_Q16, ocs_pkg::ONE_Q16);
      b1_l_ff   <= c_l_ff;
      b1_rc1_ff <= ocs_pkg::prod_type'(c_c1_ff) * ocs_pkg::K_RC1;
      b1_rc2_ff <= ocs_pkg::prod_type'(c_c2_ff) * ocs_pkg::K_RC2;
      b1_gc2_ff <= ocs_pkg::prod_type'(c_c2_ff) * ocs_pkg::K_GC2;
      b1_bc1_ff <= ocs_pkg::prod_type'(c_c1_ff) * ocs_pkg::K_BC1;
      b1_bc2_ff <= ocs_pkg::prod_type'(c_c2_ff) * ocs_pkg::K_BC2;
      b2_r_ff   <= b1_l_ff + ocs_pkg::value_type'((b1_rc1_ff + b1_rc2_ff
                                                   + ocs_pkg::HALF_Q16) >>> 16);
      b2_g_ff   <= b1_l_ff + ocs_pkg::value_type'((b1_rc1_ff - b1_gc2_ff
                                                   + ocs_pkg::HALF_Q16) >>> 16);
      b2_b_ff   <= b1_l_ff + ocs_pkg::value_type'((b1_bc2_ff - b1_bc1_ff
                                                   + ocs_pkg::HALF_Q16) >>> 16);
      b3_r_ff   <= to_byte(b2_r_ff);
      b3_g_ff   <= to_byte(b2_g_ff);
      b3_b_ff   <= to_byte(b2_b_ff);
   end

   assign rsp_valid     = b3_v_ff;
   assign rsp_red_out   = b3_r_ff;
   assign rsp_green_out = b3_g_ff;
   assign rsp_blue_out  = b3_b_ff;

endmodule

@@ hw/rtl/ocs_vec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocs_vec
// Pipelined cordic vectoring: angle of a chroma vector, one stage per step.
// ----------------------------------------------------------------------------
module ocs_vec (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ocs_pkg::value_type  in_c1,
   input  ocs_pkg::value_type  in_c2,
   input  ocs_pkg::side_type   in_side,
   output logic                out_valid,
   output ocs_pkg::angle_type  out_z,
   output ocs_pkg::side_type   out_side
);

   logic                 v_ff    [0:ocs_pkg::RUN_STAGES];
   ocs_pkg::cordic_type  x_ff    [0:ocs_pkg::RUN_STAGES];
   ocs_pkg::cordic_type  y_ff    [0:ocs_pkg::RUN_STAGES];
   ocs_pkg::angle_type   z_ff    [0:ocs_pkg::RUN_STAGES];
   ocs_pkg::side_type    side_ff [0:ocs_pkg::RUN_STAGES];

   ocs_pkg::cordic_type  x0_in;
   ocs_pkg::cordic_type  y0_in;
   ocs_pkg::angle_type   z0_in;

   // pre-rotation into the right half plane
   always_comb begin
      ocs_pkg::cordic_type xs;
      ocs_pkg::cordic_type ys;
      xs = ocs_pkg::cordic_type'(in_c1) <<< 8;
      ys = ocs_pkg::cordic_type'(in_c2) <<< 8;
      if (xs < 0) begin
         if (ys >= 0) begin
            x0_in = ys;
            y0_in = -xs;
            z0_in = ocs_pkg::PI2_Q16;
         end else begin
            x0_in = -ys;
            y0_in = xs;
            z0_in = -ocs_pkg::PI2_Q16;
         end
      end else begin
         x0_in = xs;
         y0_in = ys;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= x0_in;
      y_ff[0]    <= y0_in;
      z_ff[0]    <= z0_in;
      side_ff[0] <= in_side;
   end

   // one micro-rotation per stage, driving y toward zero
   for (genvar i = 0; i < ocs_pkg::RUN_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ocs_pkg::arc_of(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ocs_pkg::arc_of(i);
         end
         side_ff[i+1] <= side_ff[i];
      end
   end

   assign out_valid = v_ff[ocs_pkg::RUN_STAGES];
   assign out_z     = z_ff[ocs_pkg::RUN_STAGES];
   assign out_side  = side_ff[ocs_pkg::RUN_STAGES];

endmodule

@@ hw/rtl/ocs_rot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocs_rot
// Pipelined cordic rotation of a chroma vector by an angle, gain corrected.
// ----------------------------------------------------------------------------
module ocs_rot (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ocs_pkg::value_type  in_x,
   input  ocs_pkg::value_type  in_y,
   input  ocs_pkg::angle_type  in_z,
   input  ocs_pkg::side_type   in_side,
   output logic                out_valid,
   output ocs_pkg::value_type  out_x,
   output ocs_pkg::value_type  out_y,
   output ocs_pkg::side_type   out_side
);

   logic                 v_ff    [0:ocs_pkg::RUN_STAGES];
   ocs_pkg::cordic_type  x_ff    [0:ocs_pkg::RUN_STAGES];
   ocs_pkg::cordic_type  y_ff    [0:ocs_pkg::RUN_STAGES];
   ocs_pkg::angle_type   z_ff    [0:ocs_pkg::RUN_STAGES];
   ocs_pkg::side_type    side_ff [0:ocs_pkg::RUN_STAGES];

   logic                 pv_ff;
   ocs_pkg::gain_type    px_ff;
   ocs_pkg::gain_type    py_ff;
   ocs_pkg::side_type    pside_ff;
   logic                 ov_ff;
   ocs_pkg::value_type   ox_ff;
   ocs_pkg::value_type   oy_ff;
   ocs_pkg::side_type    oside_ff;

   // load into q24
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= ocs_pkg::cordic_type'(in_x) <<< 8;
      y_ff[0]    <= ocs_pkg::cordic_type'(in_y) <<< 8;
      z_ff[0]    <= in_z;
      side_ff[0] <= in_side;
   end

   // one micro-rotation per stage, driving z toward zero
   for (genvar i = 0; i < ocs_pkg::RUN_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ocs_pkg::arc_of(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ocs_pkg::arc_of(i);
         end
         side_ff[i+1] <= side_ff[i];
      end
   end

   // gain multiply, then round back to q16
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         pv_ff <= v_ff[ocs_pkg::RUN_STAGES];
         ov_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= ocs_pkg::gain_type'(x_ff[ocs_pkg::RUN_STAGES]) * ocs_pkg::GAIN_Q16;
      py_ff    <= ocs_pkg::gain_type'(y_ff[ocs_pkg::RUN_STAGES]) * ocs_pkg::GAIN_Q16;
      pside_ff <= side_ff[ocs_pkg::RUN_STAGES];
      ox_ff    <= ocs_pkg::value_type'((px_ff + ocs_pkg::GAIN_RND) >>> 24);
      oy_ff    <= ocs_pkg::value_type'((py_ff + ocs_pkg::GAIN_RND) >>> 24);
      oside_ff <= pside_ff;
   end

   assign out_valid = ov_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_side  = oside_ff;

endmodule

@@ sim/tb_orgb_color_shift.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_orgb_color_shift
// Drives pixels through the oRGB chroma shift pipeline under several offset
// settings, predicts each shifted pixel in fixed point and checks all three
// channels in order. The input side idles in random bursts, except in the
// last offset setting; offsets change only while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_orgb_color_shift;

   localparam int LATENCY   = 4 * ocs_pkg::RUN_STAGES + 20;
   localparam int WDOG_MAX  = 2000;
   localparam longint Q16   = 65536;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic       rsp_valid;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic signed [17:0] csr_data = '0;

   pixel_type pending_pixels[$];
   pixel_type shifted_pixels[$];
   longint yb_offset = 0, rg_offset = 0;
   int     fail_count = 0;
   int     pixels_sent = 0, pixels_checked = 0;
   int     idle_left = 0;
   bit     idle_enable = 1'b1;
   bit     driver_on = 1'b0;
   int     watchdog = 0;

   orgb_color_shift DUT (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- fixed point
   function automatic longint floor_div(longint a, longint d);
      if (a >= 0) return a / d;
      return -((-a + d - 1) / d);
   endfunction

   function automatic longint round_div(longint a, longint d);
      return floor_div(2 * a + d, 2 * d);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint arc(int i);
      return (i < ocs_pkg::ARC_COUNT) ? longint'(ocs_pkg::arc_of(i)) : 0;
   endfunction

   // chroma angle by cordic vectoring
   function automatic longint chroma_angle(longint cx, longint cy);
      longint x, y, z, t, xs, ys;
      x = cx * 256; y = cy * 256; z = 0;
      if (x < 0) begin
         if (y >= 0) begin t = x; x = y; y = -t; z = longint'(ocs_pkg::PI2_Q16); end
         else begin t = x; x = -y; y = t; z = -longint'(ocs_pkg::PI2_Q16); end
      end
      for (int i = 0; i < ocs_pkg::RUN_STAGES; i++) begin
         xs = floor_div(x, longint'(1) << i);
         ys = floor_div(y, longint'(1) << i);
         if (y >= 0) begin x = x + ys; y = y - xs; z += arc(i); end
         else begin x = x - ys; y = y + xs; z -= arc(i); end
      end
      return z;
   endfunction

   // chroma vector turned by z with gain correction
   function automatic void turn_chroma(inout longint a, inout longint b, input longint z);
      longint x, y, xs, ys;
      x = a * 256; y = b * 256;
      for (int i = 0; i < ocs_pkg::RUN_STAGES; i++) begin
         xs = floor_div(x, longint'(1) << i);
         ys = floor_div(y, longint'(1) << i);
         if (z >= 0) begin x = x - ys; y = y + xs; z -= arc(i); end
         else begin x = x + ys; y = y - xs; z += arc(i); end
      end
      a = round_div(x * 39797, longint'(1) << 24);
      b = round_div(y * 39797, longint'(1) << 24);
   endfunction

   function automatic longint forward_delta(longint t);
      longint m;
      if (t >= ocs_pkg::PI3_Q16) m = round_div(3 * t, 4) + ocs_pkg::PI4_Q16;
      else if (t <= -longint'(ocs_pkg::PI3_Q16)) m = round_div(3 * t, 4) - ocs_pkg::PI4_Q16;
      else m = round_div(3 * t, 2);
      return m - t;
   endfunction

   function automatic longint inverse_delta(longint t);
      longint m;
      if (t >= ocs_pkg::PI2_Q16) m = round_div(4 * t, 3) - ocs_pkg::PI3_Q16;
      else if (t <= -longint'(ocs_pkg::PI2_Q16)) m = round_div(4 * t, 3) + ocs_pkg::PI3_Q16;
      else m = round_div(2 * t, 3);
      return m - t;
   endfunction

   function automatic logic [7:0] to_channel(longint v);
      return 8'(round_div(clip(v, 0, Q16) * 255, Q16));
   endfunction

   // shifted pixel for one input pixel under the current offsets
   function automatic pixel_type shift_pixel(pixel_type p);
      longint r, g, b, l, c1, c2;
      pixel_type o;
      r = round_div(longint'(p.red) * Q16, 255);
      g = round_div(longint'(p.green) * Q16, 255);
      b = round_div(longint'(p.blue) * Q16, 255);
      l  = round_div(19595 * r + 38470 * g + 7471 * b, Q16);
      c1 = round_div(32768 * (r + g) - 65536 * b, Q16);
      c2 = round_div(56754 * (r - g), Q16);
      if (c1 != 0 || c2 != 0) turn_chroma(c1, c2, forward_delta(chroma_angle(c1, c2)));
      c1 = clip(c1 + yb_offset, -Q16, Q16);
      c2 = clip(c2 + rg_offset, -Q16, Q16);
      l  = clip(l, 0, Q16);
      if (c1 != 0 || c2 != 0) begin
         turn_chroma(c1, c2, inverse_delta(chroma_angle(c1, c2)));
         c1 = clip(c1, -Q16, Q16);
         c2 = clip(c2, -Q16, Q16);
      end
      o.red   = to_channel(l + round_div(7471 * c1 + 48733 * c2, Q16));
      o.green = to_channel(l + round_div(7471 * c1 - 26942 * c2, Q16));
      o.blue  = to_channel(l + round_div(-58065 * c1 + 10899 * c2, Q16));
      return o;
   endfunction

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (start && !busy) begin
         shifted_pixels.push_back(shift_pixel({req_red_in, req_green_in, req_blue_in}));
         pixels_sent++;
      end
      if (start && busy) begin
         // hold the current pixel until it transfers
      end else if (driver_on && pending_pixels.size() > 0 && idle_left == 0) begin
         pixel_type p;
         p = pending_pixels.pop_front();
         start        <= 1'b1;
         req_red_in   <= p.red;
         req_green_in <= p.green;
         req_blue_in  <= p.blue;
         if (idle_enable && $urandom_range(0, 9) == 0) idle_left = $urandom_range(1, 6);
      end else begin
         start <= 1'b0;
         if (idle_left > 0) idle_left--;
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (shifted_pixels.size() == 0) begin
            $error("result with no pixel pending: %0d %0d %0d",
                   rsp_red_out, rsp_green_out, rsp_blue_out);
            fail_count++;
         end else begin
            pixel_type e;
            e = shifted_pixels.pop_front();
            if (rsp_red_out !== e.red) begin
               $error("red_out expected %0d actual %0d", e.red, rsp_red_out); fail_count++;
            end
            if (rsp_green_out !== e.green) begin
               $error("green_out expected %0d actual %0d", e.green, rsp_green_out);
               fail_count++;
            end
            if (rsp_blue_out !== e.blue) begin
               $error("blue_out expected %0d actual %0d", e.blue, rsp_blue_out);
               fail_count++;
            end
         end
         pixels_checked++;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic write_offset(logic [1:0] idx, longint value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 18'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == ocs_pkg::REG_YELLOW_BLUE) yb_offset = longint'($signed(18'(value)));
      else if (idx == ocs_pkg::REG_RED_GREEN) rg_offset = longint'($signed(18'(value)));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_and_drain();
      driver_on = 1'b1;
      while (pending_pixels.size() > 0 || start) @(posedge clock);
      driver_on = 1'b0;
      while (shifted_pixels.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type p;
      case ($urandom_range(0, 5))
         0: p = {3{8'($urandom_range(0, 255))}};           // gray, zero chroma
         1: p = {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                 8'($urandom_range(0, 1) * 255)};
         default: p = pixel_type'(24'($urandom));
      endcase
      return p;
   endfunction

   initial begin
      longint offset_plan[$];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corners, grays, primaries, single bits, index out of range
      for (int i = 0; i < 8; i++)
         pending_pixels.push_back({8'(i[2] * 255), 8'(i[1] * 255), 8'(i[0] * 255)});
      pending_pixels.push_back({8'd128, 8'd128, 8'd128});
      pending_pixels.push_back({8'd1, 8'd1, 8'd1});
      for (int i = 0; i < 8; i++)
         pending_pixels.push_back({8'(1 << i), 8'(~(1 << i)), 8'(1 << (7 - i))});
      pending_pixels.push_back({8'd255, 8'd254, 8'd0});
      pending_pixels.push_back({8'd1, 8'd0, 8'd0});
      run_and_drain();
      write_offset(2'd2, 1000);
      write_offset(2'd3, -1000);

      // offset settings: extremes, beyond range, zero, random
      offset_plan = '{65536, 65536, -65536, -65536, 131071, -131072, 65536, -65536,
                      0, 0, 32768, -16384};
      for (int phase = 0; phase < 13; phase++) begin
         if (phase < 6) begin
            write_offset(ocs_pkg::REG_YELLOW_BLUE, offset_plan[2 * phase]);
            write_offset(ocs_pkg::REG_RED_GREEN, offset_plan[2 * phase + 1]);
         end else begin
            write_offset(ocs_pkg::REG_YELLOW_BLUE,
                         longint'($urandom_range(0, 131072)) - 65536);
            write_offset(ocs_pkg::REG_RED_GREEN,
                         longint'($urandom_range(0, 131072)) - 65536);
         end
         if (phase == 12) idle_enable = 1'b0;
         repeat (phase < 12 ? 130 : 170) pending_pixels.push_back(random_pixel());
         run_and_drain();
      end

      $display("pixels sent %0d, checked %0d, over %0d offset settings",
               pixels_sent, pixels_checked, 14);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

@@ orgb_color_shift.f @@
hw/rtl/ocs_pkg.sv
hw/rtl/ocs_vec.sv
hw/rtl/ocs_rot.sv
hw/rtl/orgb_color_shift.sv
sim/tb_orgb_color_shift.sv
